// ----- rtl/core/ggpm_pkg.sv -----
// ----------------------------------------------------------------------------
// ggpm_pkg
// Shared types, constants and palette tables for the gradient palette map.
// ----------------------------------------------------------------------------
package ggpm_pkg;

    localparam int unsigned PIX_W  = 8;
    localparam int unsigned SEG_W  = 3;
    localparam int unsigned PROD_W = 16;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [SEG_W-1:0] t_seg;

    typedef struct packed {
        t_pix red;
        t_pix green;
        t_pix blue;
    } t_rgb;

    // segment indexes
    localparam t_seg SEG_0 = 3'd0;
    localparam t_seg SEG_1 = 3'd1;
    localparam t_seg SEG_2 = 3'd2;
    localparam t_seg SEG_3 = 3'd3;
    localparam t_seg SEG_4 = 3'd4;
    localparam t_seg SEG_5 = 3'd5;

    // segment start values
    localparam t_pix SEG_START_1 = 8'd51;
    localparam t_pix SEG_START_2 = 8'd102;
    localparam t_pix SEG_START_3 = 8'd153;
    localparam t_pix SEG_START_4 = 8'd204;

    localparam t_pix BRIGHT_RST = 8'd200;

    // palette knot colors; knot k starts segment k, knot k+1 ends it
    function automatic t_rgb f_knot(input t_seg idx);
        t_rgb c;
        unique case (idx)
            SEG_0:   c = '{red: 8'd0,   green: 8'd100, blue: 8'd0};
            SEG_1:   c = '{red: 8'd85,  green: 8'd107, blue: 8'd47};
            SEG_2:   c = '{red: 8'd34,  green: 8'd139, blue: 8'd34};
            SEG_3:   c = '{red: 8'd46,  green: 8'd139, blue: 8'd87};
            SEG_4:   c = '{red: 8'd50,  green: 8'd205, blue: 8'd50};
            SEG_5:   c = '{red: 8'd154, green: 8'd205, blue: 8'd50};
            default: c = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
        endcase
        return c;
    endfunction

    // channels held at the start color: bit 0 red, bit 1 green, bit 2 blue
    function automatic logic [2:0] f_hold(input t_seg idx);
        logic [2:0] h;
        unique case (idx)
            SEG_2:   h = 3'b010;
            SEG_4:   h = 3'b110;
            default: h = 3'b000;
        endcase
        return h;
    endfunction

    // start value of a segment
    function automatic t_pix f_seg_start(input t_seg idx);
        t_pix s;
        unique case (idx)
            SEG_1:   s = SEG_START_1;
            SEG_2:   s = SEG_START_2;
            SEG_3:   s = SEG_START_3;
            SEG_4:   s = SEG_START_4;
            default: s = 8'd0;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/core/green_gradient_palette_map.sv -----
// ----------------------------------------------------------------------------
// green_gradient_palette_map
// Maps an 8-bit pixel intensity to a forest-green palette color.
// ----------------------------------------------------------------------------
//
//  channel   | direction | ports                         | handshake
//  ----------+-----------+-------------------------------+---------------------
//  request   | in        | i_intensity                   | start && !busy
//  result    | out       | o_red, o_green, o_blue        | o_strobe, one cycle
//  config    | in        | i_cfg_wdata (brightness)      | i_cfg_we
//
//  A request is taken every clock; busy stays low, the pipeline never fills.
//  o_strobe is high while the color it marks is on o_red, o_green and o_blue;
//  each request passes the registers r_s1_v, r_s2_t, r_c, r_p and r_q in turn.
//  Stages: contrast stretch, segment select, blend, brightness product, /255.
//  Synchronous active-low reset clears the valid bits and loads brightness 200.
//  The receiver cannot stall, so nothing holds; valid bits just advance.
//
module green_gradient_palette_map
    import ggpm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_pix i_intensity,
    input  logic i_cfg_we,
    input  t_pix i_cfg_wdata,
    output logic o_strobe,
    output t_pix o_red,
    output t_pix o_green,
    output t_pix o_blue
);

    localparam int unsigned STAGES = 5;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    t_pix              r_bright;

    // stage 1: contrast stretch about 128, factor 9/4, truncate toward zero
    logic signed [8:0]  w_d;
    logic signed [12:0] w_m;
    logic signed [12:0] w_q;
    logic signed [12:0] w_s;
    t_pix               n_s1_v;
    t_pix               r_s1_v;

    // stage 2: segment and position inside it
    t_seg               n_s2_seg;
    t_seg               r_s2_seg;
    t_pix               w_off;
    t_pix               n_s2_t;
    t_pix               r_s2_t;

    // lane inputs
    t_rgb               w_ka;
    t_rgb               w_kb;
    logic [2:0]         w_hold;

    assign busy = 1'b0;

    always_comb begin
        w_d = $signed({1'b0, i_intensity}) - 9'sd128;
        w_m = ($signed({{4{w_d[8]}}, w_d}) <<< 3) + $signed({{4{w_d[8]}}, w_d});
        // bias negatives by 3 so the shift rounds toward zero
        w_q = w_m[12] ? ((w_m + 13'sd3) >>> 2) : (w_m >>> 2);
        w_s = 13'sd128 + w_q;
        priority if (w_s < 13'sd0) begin
            n_s1_v = 8'd0;
        end else if (w_s > 13'sd255) begin
            n_s1_v = 8'd255;
        end else begin
            n_s1_v = w_s[7:0];
        end
    end

    always_comb begin
        priority if (r_s1_v >= SEG_START_4) begin
            n_s2_seg = SEG_4;
        end else if (r_s1_v >= SEG_START_3) begin
            n_s2_seg = SEG_3;
        end else if (r_s1_v >= SEG_START_2) begin
            n_s2_seg = SEG_2;
        end else if (r_s1_v >= SEG_START_1) begin
            n_s2_seg = SEG_1;
        end else begin
            n_s2_seg = SEG_0;
        end
        // offset is at most 51, so times five stays in 8 bits
        w_off  = r_s1_v - f_seg_start(n_s2_seg);
        n_s2_t = {w_off[5:0], 2'b00} + w_off;
    end

    always_comb begin
        w_ka   = f_knot(r_s2_seg);
        w_kb   = f_knot(r_s2_seg + SEG_1);
        w_hold = f_hold(r_s2_seg);
    end

    // advance valid bits one stage per clock
    assign n_vld = {r_vld[STAGES-2:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_bright <= BRIGHT_RST;
        end else begin
            r_vld <= n_vld;
            if (i_cfg_we) begin
                r_bright <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_v   <= n_s1_v;
        r_s2_seg <= n_s2_seg;
        r_s2_t   <= n_s2_t;
    end

    ggpm_channel u_red (
        .i_clk    (i_clk),
        .i_a      (w_ka.red),
        .i_b      (w_kb.red),
        .i_hold   (w_hold[0]),
        .i_t      (r_s2_t),
        .i_bright (r_bright),
        .o_c      (o_red)
    );

    ggpm_channel u_green (
        .i_clk    (i_clk),
        .i_a      (w_ka.green),
        .i_b      (w_kb.green),
        .i_hold   (w_hold[1]),
        .i_t      (r_s2_t),
        .i_bright (r_bright),
        .o_c      (o_green)
    );

    ggpm_channel u_blue (
        .i_clk    (i_clk),
        .i_a      (w_ka.blue),
        .i_b      (w_kb.blue),
        .i_hold   (w_hold[2]),
        .i_t      (r_s2_t),
        .i_bright (r_bright),
        .o_c      (o_blue)
    );

    assign o_strobe = r_vld[STAGES-1];

    // every request yields a strobe once it leaves the last stage
    a_req_to_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_strobe)
        else $error("request without a result five cycles later");

    // no strobe without a request
    a_strobe_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 5))
        else $error("result strobe without a matching request");

    // only the last segment reaches t above 250
    a_seg_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && r_s2_seg != SEG_4) |-> (r_s2_t <= 8'd250))
        else $error("segment position out of range");

    // the stretch leaves the midpoint where it is
    a_mid_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_intensity == 8'd128) |=> (r_s1_v == 8'd128))
        else $error("contrast stretch moved the midpoint");

endmodule

// ----- rtl/core/ggpm_channel.sv -----
// ----------------------------------------------------------------------------
// ggpm_channel
// One color lane: blend between two knot colors, then scale by brightness/255.
// ----------------------------------------------------------------------------
module ggpm_channel
    import ggpm_pkg::*;
(
    input  logic i_clk,
    input  t_pix i_a,
    input  t_pix i_b,
    input  logic i_hold,
    input  t_pix i_t,
    input  t_pix i_bright,
    output t_pix o_c
);

    t_pix              w_tinv;
    logic [PROD_W:0]   w_blend;
    t_pix              n_c;
    t_pix              r_c;
    logic [PROD_W-1:0] n_p;
    logic [PROD_W-1:0] r_p;
    logic [PROD_W:0]   w_div;
    t_pix              n_q;
    t_pix              r_q;

    // blend stage
    always_comb begin
        w_tinv  = 8'd255 - i_t;
        w_blend = {1'b0, PROD_W'(i_a * w_tinv)} + {1'b0, PROD_W'(i_b * i_t)};
        n_c     = i_hold ? i_a : w_blend[PROD_W-1:8];
    end

    // brightness product
    assign n_p = PROD_W'(r_c * i_bright);

    // divide by 255: (p + 1 + (p >> 8)) >> 8 is exact for p up to 255*255
    always_comb begin
        w_div = {1'b0, r_p} + (PROD_W+1)'(1) + {9'd0, r_p[PROD_W-1:8]};
        n_q   = w_div[PROD_W-1:8];
    end

    always_ff @(posedge i_clk) begin
        r_c <= n_c;
        r_p <= n_p;
        r_q <= n_q;
    end

    assign o_c = r_q;

endmodule

// ----- tb/green_gradient_palette_map_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// green_gradient_palette_map_tb
// Self-checking bench for the gradient palette map. Every accepted intensity
// request is run through an in-bench model of the stretch, segment, blend and
// brightness stages. Each strobed color is compared channel by channel with
// the oldest predicted color. Brightness moves through its extremes and
// random values between phases, and only while the pipeline is empty.
// ----------------------------------------------------------------------------
module green_gradient_palette_map_tb;
    import ggpm_pkg::*;

    localparam int CLK_HALF_NS  = 1;
    localparam int RESET_CYCLES = 12;
    localparam int IDLE_PCT     = 34;
    localparam int PHASE_ITEMS  = 160;
    localparam int LATENCY      = 5;
    localparam int SETTLE       = LATENCY + 3;
    localparam int TIMEOUT_NS   = 200000;

    // palette knots packed as {red, green, blue}; knot k starts segment k
    localparam logic [5:0][23:0] KNOTS = {
        {8'd154, 8'd205, 8'd50},
        {8'd50,  8'd205, 8'd50},
        {8'd46,  8'd139, 8'd87},
        {8'd34,  8'd139, 8'd34},
        {8'd85,  8'd107, 8'd47},
        {8'd0,   8'd100, 8'd0}
    };
    // channels that a segment holds at its start color: bit 0 red, 2 blue
    localparam logic [4:0][2:0] HELD = {3'b110, 3'b000, 3'b010, 3'b000, 3'b000};
    localparam logic [4:0][7:0] STARTS = {8'd204, 8'd153, 8'd102, 8'd51, 8'd0};

    // ------------------------------------------------------------------------
    // Color ledger: predicts the color of every accepted request and holds
    // the predictions in order until the matching strobe arrives.
    // ------------------------------------------------------------------------
    class color_ledger;
        t_rgb expected_colors[$];
        t_pix brightness;
        int   mismatch_count;

        function new();
            brightness     = BRIGHT_RST;
            mismatch_count = 0;
        endfunction

        function void set_brightness(t_pix b);
            brightness = b;
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction

        // stretch about 128, pick the segment, blend, then scale
        function t_rgb mapped_color(t_pix v);
            int   d;
            int   s;
            int   seg;
            int   t;
            int   a;
            int   b;
            int   c;
            t_rgb rgb;
            d = int'(v) - 128;
            s = 128 + (d * 9) / 4;   // int division truncates toward zero
            if (s < 0) s = 0;
            if (s > 255) s = 255;
            seg = 0;
            for (int k = 1; k < 5; k++)
                if (s >= int'(STARTS[k])) seg = k;
            t = (s - int'(STARTS[seg])) * 5;
            for (int ch = 0; ch < 3; ch++) begin
                a = int'(KNOTS[seg][8*(2-ch) +: 8]);
                b = int'(KNOTS[seg+1][8*(2-ch) +: 8]);
                if (HELD[seg][ch])
                    c = a;
                else
                    c = (a * (255 - t) + b * t) >>> 8;
                if (c > 255) c = 255;
                c = (c * int'(brightness)) / 255;
                case (ch)
                    0: rgb.red   = t_pix'(c);
                    1: rgb.green = t_pix'(c);
                    default: rgb.blue = t_pix'(c);
                endcase
            end
            return rgb;
        endfunction

        function void note_pixel(t_pix v);
            expected_colors.push_back(mapped_color(v));
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("%0t MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
            mismatch_count++;
        endtask

        task check_color(t_pix r, t_pix g, t_pix b);
            t_rgb want;
            if (expected_colors.size() == 0) begin
                report_mismatch("color with no request", int'({r, g, b}), -1);
            end else begin
                want = expected_colors.pop_front();
                if (r !== want.red)   report_mismatch("red",   r, want.red);
                if (g !== want.green) report_mismatch("green", g, want.green);
                if (b !== want.blue)  report_mismatch("blue",  b, want.blue);
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_pix i_intensity;
    logic i_cfg_we;
    t_pix i_cfg_wdata;
    logic o_strobe;
    t_pix o_red;
    t_pix o_green;
    t_pix o_blue;

    color_ledger ledger;

    green_gradient_palette_map dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_intensity (i_intensity),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Sample both sides at the rising edge; inputs only move at the falling
    // edge, and DUT registers update after this block has read them.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe)
                ledger.check_color(o_red, o_green, o_blue);
            if (start && !busy)
                ledger.note_pixel(i_intensity);
        end
    end

    // Issue one request, optionally after random idle cycles. Entered just
    // after a rising edge; returns just after the edge that took the request.
    task send_pixel(t_pix v, bit allow_idle);
        while (allow_idle && $urandom_range(99) < IDLE_PCT) begin
            @(negedge i_clk);
            start = 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        start       = 1'b1;
        i_intensity = v;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start and hold off until every predicted color has come back.
    task hold_until_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (ledger.pending() != 0) @(posedge i_clk);
    endtask

    // Brightness is only written with the pipeline empty, so no request in
    // flight sees the new value part way through.
    task write_brightness(t_pix b);
        hold_until_drained();
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = b;
        @(posedge i_clk);
        ledger.set_brightness(b);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Random intensities; halfway through, pause until the pipeline drains.
    task run_phase(int count, bit allow_idle);
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) hold_until_drained();
            send_pixel(t_pix'($urandom_range(255)), allow_idle);
        end
    endtask

    // Intensities at both clamps and near every segment edge after the contrast
    // stretch; the edge into the last segment is only probed from above.
    t_pix edge_pixels[19] = '{8'd0, 8'd1, 8'd71, 8'd72, 8'd93, 8'd94, 8'd116, 8'd117,
                              8'd127, 8'd128, 8'd129, 8'd139, 8'd140, 8'd162, 8'd163,
                              8'd184, 8'd185, 8'd254, 8'd255};

    initial begin
        t_pix phase_bright[6];
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_intensity = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        ledger      = new();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // directed: segment edges and clamps at the reset brightness
        foreach (edge_pixels[i]) send_pixel(edge_pixels[i], 1'b0);

        // extremes first, black included, then random brightness levels
        phase_bright = '{8'd255, 8'd1, 8'd0,
                         t_pix'($urandom_range(254, 2)),
                         t_pix'($urandom_range(254, 2)),
                         t_pix'($urandom_range(254, 2))};
        foreach (phase_bright[p]) begin
            write_brightness(phase_bright[p]);
            @(posedge i_clk);
            // phase one runs back to back, one request per clock, but for the halfway drain
            run_phase(PHASE_ITEMS, p != 1);
        end

        hold_until_drained();
        repeat (SETTLE) @(posedge i_clk);

        while (ledger.pending() != 0) begin
            void'(ledger.expected_colors.pop_front());
            ledger.report_mismatch("color never produced", 0, 1);
        end

        if (ledger.mismatch_count == 0)
            $display("green_gradient_palette_map test passed");
        else
            $display("green_gradient_palette_map test failed");
        $finish;
    end

    // Watchdog: a hung handshake or lost strobe ends the run here.
    initial begin
        #(TIMEOUT_NS);
        $display("green_gradient_palette_map test failed");
        $finish;
    end

endmodule
